### src/assert_macros.svh
// Assertion macros used by the checker file of the pool allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under the active-low reset.
`define SCBPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the active-low reset.
`define SCBPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/scbpa_pkg.sv
// Package with the shared types, codes and reset tables of the pool allocator.
`default_nettype none

package scbpa_pkg;

    localparam int CFG_CLASSES = 4;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int LIMIT_W     = 16;
    localparam int BLOCKS_W    = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_BASE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCKS_BASE = 3'd4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET [CFG_CLASSES] =
        '{16'd256, 16'd1024, 16'd4096, 16'd8192};
    localparam logic [BLOCKS_W-1:0] BLOCKS_RESET [CFG_CLASSES] =
        '{5'd16, 5'd12, 5'd8, 5'd4};

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] STS_GRANTED      = 3'd0;
    localparam logic [2:0] STS_TOO_LARGE    = 3'd1;
    localparam logic [2:0] STS_POOL_FULL    = 3'd2;
    localparam logic [2:0] STS_FREED        = 3'd3;
    localparam logic [2:0] STS_FREE_IGNORED = 3'd4;
    localparam logic [2:0] STS_FREE_HEAP    = 3'd5;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  pool_sel;
        logic [3:0]  block_sel;
        logic [4:0]  busy_blocks;
        logic [4:0]  peak_blocks;
        logic [31:0] alloc_total;
        logic [31:0] fallback_total;
    } t_result;

    function automatic logic [LIMIT_W-1:0] limit_reset(input int p);
        logic [1:0] idx;
        idx = p[1:0];
        return (p < CFG_CLASSES) ? LIMIT_RESET[idx] : '0;
    endfunction

    function automatic logic [BLOCKS_W-1:0] blocks_reset(input int p);
        logic [1:0] idx;
        idx = p[1:0];
        return (p < CFG_CLASSES) ? BLOCKS_RESET[idx] : '0;
    endfunction

endpackage

`default_nettype wire

### src/scbpa_in_if.sv
// Request channel interface of the pool allocator.
`default_nettype none

interface scbpa_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] req_size;
    logic [1:0]  free_pool;
    logic [3:0]  free_index;
    logic        is_pooled;

    modport source (
        output valid, op, req_size, free_pool, free_index, is_pooled,
        input  ready
    );
    modport sink (
        input  valid, op, req_size, free_pool, free_index, is_pooled,
        output ready
    );
endinterface

`default_nettype wire

### src/scbpa_out_if.sv
// Result channel interface of the pool allocator.
`default_nettype none

interface scbpa_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  pool_sel;
    logic [3:0]  block_sel;
    logic [4:0]  busy_blocks;
    logic [4:0]  peak_blocks;
    logic [31:0] alloc_total;
    logic [31:0] fallback_total;

    modport source (
        output valid, status, pool_sel, block_sel, busy_blocks, peak_blocks,
               alloc_total, fallback_total,
        input  ready
    );
    modport sink (
        input  valid, status, pool_sel, block_sel, busy_blocks, peak_blocks,
               alloc_total, fallback_total,
        output ready
    );
endinterface

`default_nettype wire

### src/scbpa_ctrl.sv
// Controller state machine that sequences load and update of each request.
`default_nettype none

module scbpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output scbpa_pkg::t_cmd   o_cmd
);
    import scbpa_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    t_cmd cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        cmd         = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.exec    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

### src/scbpa_dp.sv
// Datapath with the pool registers, bitmaps, counters and lowest-free-block encoder.
`default_nettype none

module scbpa_dp #(
    parameter int POOL_CLASSES = 4,
    parameter int MAX_BLOCKS   = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  scbpa_pkg::t_cmd                     i_cmd,
    input  logic                                i_op,
    input  logic [31:0]                         i_req_size,
    input  logic [1:0]                          i_free_pool,
    input  logic [3:0]                          i_free_index,
    input  logic                                i_is_pooled,
    input  logic                                i_cfg_we,
    input  logic [scbpa_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [scbpa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output scbpa_pkg::t_result                  o_result
);
    import scbpa_pkg::*;

    localparam int PW = (POOL_CLASSES > 1) ? $clog2(POOL_CLASSES) : 1;
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int UW = $clog2(MAX_BLOCKS + 1);

    logic [LIMIT_W-1:0]     r_limit  [POOL_CLASSES];
    logic [BLOCKS_W-1:0]    r_blocks [POOL_CLASSES];
    logic [MAX_BLOCKS-1:0]  r_map    [POOL_CLASSES];
    logic [UW-1:0]          r_used   [POOL_CLASSES];
    logic [UW-1:0]          r_peak   [POOL_CLASSES];
    logic [COUNT_WIDTH-1:0] r_req    [POOL_CLASSES];
    logic [COUNT_WIDTH-1:0] r_ovf    [POOL_CLASSES];

    logic          r_op;
    logic          r_heap;
    logic [PW-1:0] r_pool;
    logic [3:0]    r_fidx;
    t_result       r_res;

    logic          sel_found;
    logic [PW-1:0] sel_pool;
    logic          free_ok;

    logic [MAX_BLOCKS-1:0]  cur_map;
    logic [BLOCKS_W-1:0]    cur_blocks;
    logic [UW-1:0]          cur_used;
    logic [UW-1:0]          cur_peak;
    logic [COUNT_WIDTH-1:0] cur_req;
    logic [COUNT_WIDTH-1:0] cur_ovf;
    logic [MAX_BLOCKS-1:0]  avail;
    logic [MAX_BLOCKS-1:0]  lowest;
    logic [MAX_BLOCKS-1:0]  fsel;
    logic [IW-1:0]          grant_idx;
    logic                   busy;

    logic [MAX_BLOCKS-1:0]  n_map;
    logic [UW-1:0]          n_used;
    logic [UW-1:0]          n_peak;
    logic [COUNT_WIDTH-1:0] n_req;
    logic [COUNT_WIDTH-1:0] n_ovf;
    t_result                n_res;

    // Pool choice at load time: the lowest pool whose limit covers the size.
    always_comb begin
        sel_found = 1'b0;
        sel_pool  = '0;
        for (int p = POOL_CLASSES - 1; p >= 0; p--) begin
            if ({16'd0, r_limit[p]} >= i_req_size) begin
                sel_found = 1'b1;
                sel_pool  = PW'(p);
            end
        end
        free_ok = i_is_pooled && (32'(i_free_pool) < POOL_CLASSES);
    end

    always_comb begin
        cur_map    = r_map[r_pool];
        cur_blocks = r_blocks[r_pool];
        cur_used   = r_used[r_pool];
        cur_peak   = r_peak[r_pool];
        cur_req    = r_req[r_pool];
        cur_ovf    = r_ovf[r_pool];

        for (int i = 0; i < MAX_BLOCKS; i++) begin
            avail[i] = !cur_map[i] && (32'(i) < 32'(cur_blocks));
            fsel[i]  = (32'(r_fidx) == 32'(i));
        end
        lowest    = avail & (~avail + MAX_BLOCKS'(1));
        grant_idx = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (lowest[i]) begin
                grant_idx = grant_idx | IW'(i);
            end
        end
        busy = |(cur_map & fsel);

        n_map  = cur_map;
        n_used = cur_used;
        n_peak = cur_peak;
        n_req  = cur_req;
        n_ovf  = cur_ovf;
        n_res  = '0;

        if (r_heap) begin
            n_res.status = (r_op == OP_ALLOC) ? STS_TOO_LARGE : STS_FREE_HEAP;
        end else begin
            if (r_op == OP_ALLOC) begin
                n_req = cur_req + COUNT_WIDTH'(1);
                if (|avail) begin
                    n_map           = cur_map | lowest;
                    n_used          = cur_used + UW'(1);
                    n_peak          = (n_used > cur_peak) ? n_used : cur_peak;
                    n_res.status    = STS_GRANTED;
                    n_res.block_sel = 4'(grant_idx);
                end else begin
                    n_ovf        = cur_ovf + COUNT_WIDTH'(1);
                    n_res.status = STS_POOL_FULL;
                end
            end else begin
                n_res.block_sel = r_fidx;
                if (busy) begin
                    n_map        = cur_map & ~fsel;
                    n_used       = (cur_used == '0) ? '0 : cur_used - UW'(1);
                    n_res.status = STS_FREED;
                end else begin
                    n_res.status = STS_FREE_IGNORED;
                end
            end
            n_res.pool_sel       = 2'(r_pool);
            n_res.busy_blocks    = 5'(n_used);
            n_res.peak_blocks    = 5'(n_peak);
            n_res.alloc_total    = 32'(n_req);
            n_res.fallback_total = 32'(n_ovf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < POOL_CLASSES; p++) begin
                r_limit[p]  <= limit_reset(p);
                r_blocks[p] <= blocks_reset(p);
                r_map[p]    <= '0;
                r_used[p]   <= '0;
                r_peak[p]   <= '0;
                r_req[p]    <= '0;
                r_ovf[p]    <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                for (int p = 0; p < POOL_CLASSES; p++) begin
                    if (p < CFG_CLASSES) begin
                        if (i_cfg_addr == REG_LIMIT_BASE + CFG_ADDR_W'(p)) begin
                            r_limit[p] <= i_cfg_data;
                        end
                        if (i_cfg_addr == REG_BLOCKS_BASE + CFG_ADDR_W'(p)) begin
                            r_blocks[p] <= i_cfg_data[BLOCKS_W-1:0];
                        end
                    end
                end
            end
            if (i_cmd.exec && !r_heap) begin
                r_map[r_pool]  <= n_map;
                r_used[r_pool] <= n_used;
                r_peak[r_pool] <= n_peak;
                r_req[r_pool]  <= n_req;
                r_ovf[r_pool]  <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_fidx <= i_free_index;
            if (i_op == OP_ALLOC) begin
                r_pool <= sel_pool;
                r_heap <= !sel_found;
            end else begin
                r_pool <= free_ok ? PW'(i_free_pool) : '0;
                r_heap <= !free_ok;
            end
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

### src/size_class_block_pool_allocator.sv
// Top level of the size-class block pool allocator.
//
//   channel   direction  signals                 transfer when
//   i_in      in         valid ready + request   valid && ready
//   o_out     out        valid ready + result    valid && ready
//   i_cfg     in         we addr data            we high
//
// Each request has a load step, which registers it and picks the pool by
// comparing the size limits, and an update step for the read-modify-write of
// that pool's bitmap and counters through the lowest-free-block encoder.
// The result sits in an output register; the update step waits while it is
// still held by the sink, and the next request is taken right after.
// Synchronous reset clears pool bitmaps and counters and reloads limits.
`default_nettype none

module size_class_block_pool_allocator #(
    parameter int POOL_CLASSES = 4,
    parameter int MAX_BLOCKS   = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    scbpa_in_if.sink                          i_in,
    scbpa_out_if.source                       o_out,
    input  logic                              i_cfg_we,
    input  logic [scbpa_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [scbpa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import scbpa_pkg::*;

    t_cmd    cmd;
    t_result res;
    logic    in_ready;
    logic    out_valid;

    scbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    scbpa_dp #(
        .POOL_CLASSES (POOL_CLASSES),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_in.op),
        .i_req_size   (i_in.req_size),
        .i_free_pool  (i_in.free_pool),
        .i_free_index (i_in.free_index),
        .i_is_pooled  (i_in.is_pooled),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_result     (res)
    );

    assign i_in.ready           = in_ready;
    assign o_out.valid          = out_valid;
    assign o_out.status         = res.status;
    assign o_out.pool_sel       = res.pool_sel;
    assign o_out.block_sel      = res.block_sel;
    assign o_out.busy_blocks    = res.busy_blocks;
    assign o_out.peak_blocks    = res.peak_blocks;
    assign o_out.alloc_total    = res.alloc_total;
    assign o_out.fallback_total = res.fallback_total;

endmodule

`default_nettype wire

### src/scbpa_checker.sv
// Port-level assertion checker of the pool allocator and its bind statement.
`default_nettype none

`include "assert_macros.svh"

module scbpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [1:0]  i_pool_sel,
    input logic [3:0]  i_block_sel,
    input logic [4:0]  i_busy_blocks,
    input logic [4:0]  i_peak_blocks,
    input logic [31:0] i_alloc_total,
    input logic [31:0] i_fallback_total
);
    import scbpa_pkg::*;

    logic heap_result;
    logic heap_zero;
    logic out_stall;
    logic in_xfer;
    logic out_heap;
    logic out_grant;
    logic grant_ok;

    assign heap_result = (i_status == STS_TOO_LARGE) || (i_status == STS_FREE_HEAP);
    assign heap_zero   = (i_pool_sel == '0) && (i_block_sel == '0) &&
                         (i_busy_blocks == '0) && (i_peak_blocks == '0) &&
                         (i_alloc_total == '0) && (i_fallback_total == '0);
    assign out_stall   = i_out_valid && !i_out_ready;
    assign in_xfer     = i_in_valid && i_in_ready;
    assign out_heap    = i_out_valid && heap_result;
    assign out_grant   = i_out_valid && (i_status == STS_GRANTED);
    assign grant_ok    = (i_busy_blocks != '0) && (i_peak_blocks >= i_busy_blocks);

    `SCBPA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid, "result dropped")
    `SCBPA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_xfer, !i_in_ready, "taken in update")
    `SCBPA_ASSERT_NOW(a_heap_zero, i_clk, i_rst_n, out_heap, heap_zero, "heap result with stats")
    `SCBPA_ASSERT_NOW(a_grant_counts, i_clk, i_rst_n, out_grant, grant_ok, "grant with bad counts")

endmodule

bind size_class_block_pool_allocator scbpa_checker u_scbpa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_status         (o_out.status),
    .i_pool_sel       (o_out.pool_sel),
    .i_block_sel      (o_out.block_sel),
    .i_busy_blocks    (o_out.busy_blocks),
    .i_peak_blocks    (o_out.peak_blocks),
    .i_alloc_total    (o_out.alloc_total),
    .i_fallback_total (o_out.fallback_total)
);

`default_nettype wire
